// ----- rtl/wvsl_pkg.sv -----
// Shared types, widths and helpers for the walk velocity slew limiter.
package wvsl_pkg;

    // Velocity word width (signed Q7.16)
    localparam int VEL_W      = 24;
    localparam int W_W        = 19;   // walk direction component, Q.14
    localparam int TGT_W      = 25;   // target velocity component
    localparam int DIF_W      = 26;   // target minus velocity
    localparam int MUL_W      = 27;   // shared multiplier operand width
    localparam int ACC_W      = 56;   // product accumulator
    localparam int NUM_W      = 52;   // iterative unit dividend / radicand
    localparam int DEN_W      = 26;   // divisor / root width
    localparam int RES_W      = 27;   // quotient width
    localparam int REM_W      = 30;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQRT_STEPS = NUM_W / 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_ACCEL = 2'd0;
    localparam logic [1:0] CFG_MAX_VEL   = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_WA, S_WB, S_WC, S_L2, S_L2C, S_NSQ, S_NSQW, S_NDS, S_NDW,
        S_TA, S_TB, S_D2, S_ST1, S_ST2, S_CMP, S_DSQW, S_MD, S_DDS, S_DDW, S_FIN
    } t_state;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_itu_req;

    // Clamp a wide velocity sum to the velocity word
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [RES_W:0] x);
        logic signed [RES_W:0] hi;
        logic signed [RES_W:0] lo;
        hi = (RES_W+1)'((1 <<< (VEL_W-1)) - 1);
        lo = -(RES_W+1)'(1 <<< (VEL_W-1));
        if (x > hi)      sat_vel = hi[VEL_W-1:0];
        else if (x < lo) sat_vel = lo[VEL_W-1:0];
        else             sat_vel = x[VEL_W-1:0];
    endfunction

endpackage

// ----- rtl/walk_velocity_slew_limiter_top.sv -----
// Top level of the walk velocity slew limiter: sequencer, shared multiplier and state.
//
// Input stream (s_axis): one item per tick carrying heading, forward and strafe
// controls and the step time. The block moves its kept 3D velocity toward the
// target walk velocity, limited by max acceleration times step time, and sends
// one item per tick on the output stream (m_axis): the new velocity in tdata and
// the at-target flag in tuser.
// Configuration: write max acceleration (index 0) and max velocity (index 1)
// through the cfg channel while the block is idle; it is always ready.
// Resources: one 27x27 multiplier and one iterative divide/square-root unit are
// shared under a sequencer. An item is shortest when the direction needs no
// normalising and the target is reached, and longest when both square roots
// and six divisions run.
// Items are handled one at a time; s_axis_tready is high only when idle.
// Reset clears the velocity, both registers and the output valid.
// A stalled receiver holds the result in the output register; the block
// takes the next item meanwhile and waits only to hand over its own result.
module walk_velocity_slew_limiter_top import wvsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // heading_x, heading_y, heading_z, forward_amount, strafe_amount, step_time
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // speed_x, speed_y, speed_z
    output logic [71:0] o_m_axis_tdata,
    // at_target
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [1:0] r_i;

    logic signed [15:0]      r_h [3];
    logic signed [15:0]      r_fw, r_st;
    logic [15:0]             r_dt;
    logic [23:0]             r_mac;
    logic [22:0]             r_mv;
    logic signed [W_W-1:0]   r_w [3];
    logic signed [TGT_W-1:0] r_tgt [3];
    logic signed [VEL_W-1:0] r_vel [3];
    logic signed [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0]        r_d2;
    logic [VEL_W-1:0]        r_step;
    logic [DEN_W-1:0]        r_len;
    logic                    r_at;
    logic                    r_ovalid;
    logic [71:0]             r_odata;
    logic                    r_oat;

    logic signed [MUL_W-1:0]   m_a, m_b;
    logic signed [2*MUL_W-1:0] m_p;
    logic signed [DIF_W-1:0]   dd;
    logic [W_W-1:0]            w_mag;
    logic [ACC_W-1:0]          acc_mag;
    logic signed [ACC_W-1:0]   acc_rnd;

    t_itu_req         itu_req;
    logic [NUM_W-1:0] itu_num;
    logic             itu_done;
    logic [RES_W-1:0] itu_res;
    logic signed [RES_W:0] q_s;

    wvsl_itu u_itu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (itu_req),
        .i_num   (itu_num),
        .i_den   (r_len),
        .o_done  (itu_done),
        .o_res   (itu_res)
    );

    // Shared arithmetic terms
    always_comb begin
        dd      = DIF_W'(r_tgt[r_i]) - DIF_W'(r_vel[r_i]);
        w_mag   = r_w[r_i][W_W-1] ? W_W'(-r_w[r_i]) : W_W'(r_w[r_i]);
        acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        acc_rnd = (r_acc + ACC_W'(1 <<< 13)) >>> 14;
        q_s     = (RES_W+1)'(itu_res);
        m_p     = m_a * m_b;
    end

    // Next state, multiplier operands and unit requests
    always_comb begin
        n_state       = r_state;
        m_a           = '0;
        m_b           = '0;
        itu_req.start = 1'b0;
        itu_req.sqrt  = 1'b0;
        itu_num       = r_acc[NUM_W-1:0];
        unique case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_WA;
            S_WA: begin
                m_a = MUL_W'(r_h[r_i]);
                m_b = MUL_W'(r_fw);
                n_state = S_WB;
            end
            S_WB: begin
                m_a = (r_i == 2'd0) ? MUL_W'(r_h[2]) : MUL_W'(r_h[0]);
                m_b = MUL_W'(r_st);
                n_state = S_WC;
            end
            S_WC: n_state = (r_i == 2'd2) ? S_L2 : S_WA;
            S_L2: begin
                m_a = MUL_W'(r_w[r_i]);
                m_b = MUL_W'(r_w[r_i]);
                if (r_i == 2'd2) n_state = S_L2C;
            end
            S_L2C: n_state = (r_acc > ACC_W'(64'd1 << 28)) ? S_NSQ : S_TA;
            S_NSQ: begin
                itu_req.start = 1'b1;
                itu_req.sqrt  = 1'b1;
                n_state = S_NSQW;
            end
            S_NSQW: if (itu_done) n_state = S_NDS;
            S_NDS: begin
                itu_req.start = 1'b1;
                itu_num = (NUM_W'(w_mag) << 14) + NUM_W'(r_len >> 1);
                n_state = S_NDW;
            end
            S_NDW: if (itu_done) n_state = (r_i == 2'd2) ? S_TA : S_NDS;
            S_TA: begin
                m_a = MUL_W'(r_w[r_i]);
                m_b = MUL_W'({1'b0, r_mv});
                n_state = S_TB;
            end
            S_TB: n_state = (r_i == 2'd2) ? S_D2 : S_TA;
            S_D2: begin
                m_a = MUL_W'(dd);
                m_b = MUL_W'(dd);
                if (r_i == 2'd2) n_state = S_ST1;
            end
            S_ST1: begin
                m_a = MUL_W'({1'b0, r_mac});
                m_b = MUL_W'({1'b0, r_dt});
                n_state = S_ST2;
            end
            S_ST2: begin
                m_a = MUL_W'({1'b0, r_step});
                m_b = MUL_W'({1'b0, r_step});
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_d2 <= ACC_W'(r_acc)) begin
                    n_state = S_FIN;
                end else if (r_step == '0) begin
                    n_state = S_FIN;
                end else begin
                    itu_req.start = 1'b1;
                    itu_req.sqrt  = 1'b1;
                    itu_num = r_d2[NUM_W-1:0];
                    n_state = S_DSQW;
                end
            end
            S_DSQW: if (itu_done) n_state = S_MD;
            S_MD: begin
                m_a = MUL_W'(dd);
                m_b = MUL_W'({1'b0, r_step});
                n_state = S_DDS;
            end
            S_DDS: begin
                itu_req.start = 1'b1;
                itu_num = acc_mag[NUM_W-1:0] + NUM_W'(r_len >> 1);
                n_state = S_DDW;
            end
            S_DDW: if (itu_done) n_state = (r_i == 2'd2) ? S_FIN : S_MD;
            S_FIN: if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mac    <= '0;
            r_mv     <= '0;
            for (int k = 0; k < 3; k++) r_vel[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && i_cfg_index == CFG_MAX_ACCEL) r_mac <= i_cfg_data;
            if (i_cfg_valid && i_cfg_index == CFG_MAX_VEL)   r_mv  <= i_cfg_data[22:0];
            if (r_state == S_FIN && (!r_ovalid || i_m_axis_tready)) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
            // Commit the velocity
            if (r_state == S_CMP && r_d2 <= ACC_W'(r_acc)) begin
                for (int k = 0; k < 3; k++) r_vel[k] <= sat_vel((RES_W+1)'(r_tgt[k]));
            end
            if (r_state == S_DDW && itu_done) begin
                r_vel[r_i] <= sat_vel((RES_W+1)'(r_vel[r_i]) +
                                      (r_acc[ACC_W-1] ? -q_s : q_s));
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i    <= 2'd0;
                r_h[0] <= i_s_axis_tdata[15:0];
                r_h[1] <= i_s_axis_tdata[31:16];
                r_h[2] <= i_s_axis_tdata[47:32];
                r_fw   <= i_s_axis_tdata[63:48];
                r_st   <= i_s_axis_tdata[79:64];
                r_dt   <= i_s_axis_tdata[95:80];
            end
            S_WA: r_acc <= ACC_W'(m_p);
            S_WB: begin
                if (r_i == 2'd0)      r_acc <= r_acc - ACC_W'(m_p);
                else if (r_i == 2'd2) r_acc <= r_acc + ACC_W'(m_p);
            end
            S_WC: begin
                r_w[r_i] <= acc_rnd[W_W-1:0];
                r_i      <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            S_L2: begin
                r_acc <= ((r_i == 2'd0) ? '0 : r_acc) + ACC_W'(m_p);
                r_i   <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            S_NSQW: if (itu_done) r_len <= itu_res[DEN_W-1:0];
            S_NDW: begin
                if (itu_done) begin
                    r_w[r_i] <= r_w[r_i][W_W-1] ? -W_W'(itu_res) : W_W'(itu_res);
                    r_i      <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                end
            end
            S_TA: r_acc <= ACC_W'(m_p);
            S_TB: begin
                r_tgt[r_i] <= acc_rnd[TGT_W-1:0];
                r_i        <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            S_D2: begin
                r_acc <= ((r_i == 2'd0) ? '0 : r_acc) + ACC_W'(m_p);
                r_i   <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            S_ST1: begin
                r_d2   <= ACC_W'(r_acc);
                r_step <= VEL_W'(m_p >>> 16);
            end
            S_ST2: r_acc <= ACC_W'(m_p);
            S_CMP: r_at <= (r_d2 <= ACC_W'(r_acc));
            S_DSQW: begin
                if (itu_done) begin
                    r_len <= itu_res[DEN_W-1:0];
                    r_i   <= 2'd0;
                end
            end
            S_MD: r_acc <= ACC_W'(m_p);
            S_DDS: ;
            S_DDW: if (itu_done) r_i <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            S_FIN: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    r_odata <= {r_vel[2], r_vel[1], r_vel[0]};
                    r_oat   <= r_at;
                end
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready   = (r_state == S_IDLE);
    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_oat;
    assign o_cfg_ready       = 1'b1;

    // Accepted item starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_WA))
        else $error("sequencer did not start on accepted item");

    // Unit completes only while the sequencer waits for it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        itu_done |-> (r_state == S_NSQW || r_state == S_NDW ||
                      r_state == S_DSQW || r_state == S_DDW))
        else $error("iterative unit result arrived outside a wait state");

    // Normalised direction stays within unit length
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NDW && itu_done) |-> (itu_res <= RES_W'(16385)))
        else $error("normalised component exceeds one");

endmodule

// ----- rtl/wvsl_itu.sv -----
// Iterative unit: restoring division one bit a cycle, or integer square root two bits a cycle.
module wvsl_itu import wvsl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_itu_req         i_req,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [RES_W-1:0] o_res
);

    logic             r_busy;
    logic             r_sqrt;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [REM_W-1:0] r_rem;
    logic [RES_W-1:0] r_q;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] sub;
    logic             ge;

    // Shift in the next digit and try the subtraction
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[REM_W-3:0], r_num[NUM_W-1 -: 2]};
            sub    = {1'b0, r_q, 2'b01};
        end else begin
            rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
            sub    = REM_W'(r_den);
        end
        ge = (rem_sh >= sub);
    end

    // Control: start, count down, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_cnt  <= i_req.sqrt ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - sub : rem_sh;
            r_q   <= {r_q[RES_W-2:0], ge};
            r_num <= r_sqrt ? {r_num[NUM_W-3:0], 2'b00} : {r_num[NUM_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_q;

endmodule
